/* rtl/sprq_pkg.sv */
// Shared types and constants for the sleep and priority ready queue.
`default_nettype none
package sprq_pkg;

    // Operation codes
    localparam logic [1:0] OP_READY = 2'd0;
    localparam logic [1:0] OP_SLEEP = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;
    localparam logic [1:0] OP_PICK  = 2'd3;

    localparam int ID_W    = 8;
    localparam int PRIO_W  = 6;
    localparam int TICK_W  = 32;
    localparam int WOKEN_W = 7;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 24;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_WAKE,
        ST_FINISH
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic cap;        // capture the input transfer, clear the result
        logic rdy_ins;    // insert the captured task into the ready queue
        logic slp_ins;    // insert the captured task into the sleep queue
        logic rdy_pop;    // pop the ready queue head
        logic wake_step;  // move the sleep queue head into the ready queue
        logic finish;     // load the result register
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic [1:0] op;
        logic       wake_due;
    } sts_t;

endpackage
`default_nettype wire

/* rtl/sprq_datapath.sv */
// Datapath: input capture, two sorted cell rows and the result register.
`default_nettype none
module sprq_datapath #(
    parameter int MAX_TASKS       = 64,
    parameter int PRIORITY_LEVELS = 64
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    input  wire logic [sprq_pkg::S_DATA_W-1:0]    in_data,
    input  wire sprq_pkg::cmd_t                   cmd,
    output sprq_pkg::sts_t                        sts,
    output logic [sprq_pkg::M_DATA_W-1:0]         out_data
);
    localparam int CW = $clog2(MAX_TASKS + 1);

    function automatic logic [sprq_pkg::PRIO_W-1:0] clamp(
        input logic [sprq_pkg::PRIO_W-1:0] p
    );
        logic [sprq_pkg::PRIO_W-1:0] r;
        r = p;
        if (int'(p) >= PRIORITY_LEVELS) r = sprq_pkg::PRIO_W'(PRIORITY_LEVELS - 1);
        return r;
    endfunction

    // Captured input
    logic [1:0]                  op_reg;
    logic [sprq_pkg::ID_W-1:0]   id_reg;
    logic [sprq_pkg::PRIO_W-1:0] prio_reg;
    logic [sprq_pkg::TICK_W-1:0] tick_reg;
    logic [sprq_pkg::PRIO_W-1:0] run_reg;

    // Result accumulators
    logic [sprq_pkg::ID_W-1:0]    task_reg;
    logic                         valid_reg;
    logic [sprq_pkg::WOKEN_W-1:0] woken_reg;
    logic                         status_reg;

    // Cell rows
    logic [sprq_pkg::ID_W-1:0]   r_id_reg   [MAX_TASKS];
    logic [sprq_pkg::PRIO_W-1:0] r_prio_reg [MAX_TASKS];
    logic [sprq_pkg::ID_W-1:0]   s_id_reg   [MAX_TASKS];
    logic [sprq_pkg::PRIO_W-1:0] s_prio_reg [MAX_TASKS];
    logic [sprq_pkg::TICK_W-1:0] s_wake_reg [MAX_TASKS];
    logic [CW-1:0]               r_cnt_reg, s_cnt_reg;

    logic [sprq_pkg::ID_W-1:0]   r_id_next   [MAX_TASKS];
    logic [sprq_pkg::PRIO_W-1:0] r_prio_next [MAX_TASKS];
    logic [sprq_pkg::ID_W-1:0]   s_id_next   [MAX_TASKS];
    logic [sprq_pkg::PRIO_W-1:0] s_prio_next [MAX_TASKS];
    logic [sprq_pkg::TICK_W-1:0] s_wake_next [MAX_TASKS];
    logic [CW-1:0]               r_cnt_next, s_cnt_next;

    logic                        r_full, s_full, r_ins_ok, s_ins_ok;
    logic [sprq_pkg::ID_W-1:0]   ins_id;
    logic [sprq_pkg::PRIO_W-1:0] ins_prio;
    logic [MAX_TASKS-1:0]        r_before, s_before;
    logic                        preempt;

    assign r_full   = (r_cnt_reg == CW'(MAX_TASKS));
    assign s_full   = (s_cnt_reg == CW'(MAX_TASKS));
    assign ins_id   = cmd.wake_step ? s_id_reg[0]   : id_reg;
    assign ins_prio = cmd.wake_step ? s_prio_reg[0] : prio_reg;
    assign r_ins_ok = (cmd.rdy_ins || cmd.wake_step) && !r_full;
    assign s_ins_ok = cmd.slp_ins && !s_full;

    assign sts.op       = op_reg;
    assign sts.wake_due = (s_cnt_reg != '0) && (s_wake_reg[0] <= tick_reg);

    assign preempt = ((op_reg == sprq_pkg::OP_READY) || (op_reg == sprq_pkg::OP_TICK))
                     && (r_cnt_reg != '0) && (r_prio_reg[0] >= run_reg);

    // Per-cell ordering against the item being inserted
    always_comb begin
        for (int i = 0; i < MAX_TASKS; i++) begin
            r_before[i] = (CW'(i) < r_cnt_reg) && (r_prio_reg[i] >= ins_prio);
            s_before[i] = (CW'(i) < s_cnt_reg) && (s_wake_reg[i] <= tick_reg);
        end
    end

    // Ready row: keep, take the new item, or shift
    always_comb begin
        r_cnt_next = r_cnt_reg;
        for (int i = 0; i < MAX_TASKS; i++) begin
            r_id_next[i]   = r_id_reg[i];
            r_prio_next[i] = r_prio_reg[i];
        end
        if (r_ins_ok) begin
            r_cnt_next = r_cnt_reg + 1'b1;
            for (int i = 0; i < MAX_TASKS; i++) begin
                if (!r_before[i]) begin
                    if (i == 0 || r_before[(i == 0) ? 0 : i - 1]) begin
                        r_id_next[i]   = ins_id;
                        r_prio_next[i] = ins_prio;
                    end else begin
                        r_id_next[i]   = r_id_reg[(i == 0) ? 0 : i - 1];
                        r_prio_next[i] = r_prio_reg[(i == 0) ? 0 : i - 1];
                    end
                end
            end
        end else if (cmd.rdy_pop && r_cnt_reg != '0) begin
            r_cnt_next = r_cnt_reg - 1'b1;
            for (int i = 0; i < MAX_TASKS - 1; i++) begin
                r_id_next[i]   = r_id_reg[i + 1];
                r_prio_next[i] = r_prio_reg[i + 1];
            end
        end
    end

    // Sleep row: insert by wake tick, pop the head on a wake step
    always_comb begin
        s_cnt_next = s_cnt_reg;
        for (int i = 0; i < MAX_TASKS; i++) begin
            s_id_next[i]   = s_id_reg[i];
            s_prio_next[i] = s_prio_reg[i];
            s_wake_next[i] = s_wake_reg[i];
        end
        if (s_ins_ok) begin
            s_cnt_next = s_cnt_reg + 1'b1;
            for (int i = 0; i < MAX_TASKS; i++) begin
                if (!s_before[i]) begin
                    if (i == 0 || s_before[(i == 0) ? 0 : i - 1]) begin
                        s_id_next[i]   = id_reg;
                        s_prio_next[i] = prio_reg;
                        s_wake_next[i] = tick_reg;
                    end else begin
                        s_id_next[i]   = s_id_reg[(i == 0) ? 0 : i - 1];
                        s_prio_next[i] = s_prio_reg[(i == 0) ? 0 : i - 1];
                        s_wake_next[i] = s_wake_reg[(i == 0) ? 0 : i - 1];
                    end
                end
            end
        end else if (cmd.wake_step) begin
            s_cnt_next = s_cnt_reg - 1'b1;
            for (int i = 0; i < MAX_TASKS - 1; i++) begin
                s_id_next[i]   = s_id_reg[i + 1];
                s_prio_next[i] = s_prio_reg[i + 1];
                s_wake_next[i] = s_wake_reg[i + 1];
            end
        end
    end

    // Cell storage, no reset needed beyond the counts
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_TASKS; i++) begin
            r_id_reg[i]   <= r_id_next[i];
            r_prio_reg[i] <= r_prio_next[i];
            s_id_reg[i]   <= s_id_next[i];
            s_prio_reg[i] <= s_prio_next[i];
            s_wake_reg[i] <= s_wake_next[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            r_cnt_reg <= '0;
            s_cnt_reg <= '0;
        end else begin
            r_cnt_reg <= r_cnt_next;
            s_cnt_reg <= s_cnt_next;
        end
    end

    // Capture the input and accumulate the result
    always_ff @(posedge aclk) begin
        if (cmd.cap) begin
            op_reg     <= in_data[1:0];
            id_reg     <= in_data[9:2];
            prio_reg   <= clamp(in_data[15:10]);
            tick_reg   <= in_data[47:16];
            run_reg    <= clamp(in_data[53:48]);
            task_reg   <= '0;
            valid_reg  <= 1'b0;
            woken_reg  <= '0;
            status_reg <= 1'b0;
        end else begin
            if ((cmd.rdy_ins && r_full) || (cmd.slp_ins && s_full) ||
                (cmd.wake_step && r_full)) begin
                status_reg <= 1'b1;
            end
            if (cmd.wake_step && !r_full && woken_reg != '1) begin
                woken_reg <= woken_reg + 1'b1;
            end
            if (cmd.rdy_pop && r_cnt_reg != '0) begin
                task_reg  <= r_id_reg[0];
                valid_reg <= 1'b1;
            end
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            out_data <= {6'd0, status_reg, woken_reg, preempt, valid_reg, task_reg};
        end
    end

endmodule
`default_nettype wire

/* rtl/sprq_ctrl.sv */
// Controller: sequences one operation at a time and owns both handshakes.
`default_nettype none
module sprq_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    input  wire sprq_pkg::sts_t  sts,
    output sprq_pkg::cmd_t       cmd
);
    sprq_pkg::state_t state_reg, state_next;
    logic             mv_reg, mv_next;

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            sprq_pkg::ST_IDLE: begin
                if (s_tvalid && !mv_reg) state_next = sprq_pkg::ST_EXEC;
            end
            sprq_pkg::ST_EXEC: begin
                if (sts.op == sprq_pkg::OP_TICK) state_next = sprq_pkg::ST_WAKE;
                else                             state_next = sprq_pkg::ST_FINISH;
            end
            sprq_pkg::ST_WAKE: begin
                if (!sts.wake_due) state_next = sprq_pkg::ST_FINISH;
            end
            sprq_pkg::ST_FINISH: begin
                state_next = sprq_pkg::ST_IDLE;
            end
            default: begin
                state_next = sprq_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb begin
        cmd      = '0;
        s_tready = 1'b0;
        case (state_reg)
            sprq_pkg::ST_IDLE: begin
                s_tready = !mv_reg;
                cmd.cap  = s_tvalid && !mv_reg;
            end
            sprq_pkg::ST_EXEC: begin
                cmd.rdy_ins = (sts.op == sprq_pkg::OP_READY);
                cmd.slp_ins = (sts.op == sprq_pkg::OP_SLEEP);
                cmd.rdy_pop = (sts.op == sprq_pkg::OP_PICK);
            end
            sprq_pkg::ST_WAKE: begin
                cmd.wake_step = sts.wake_due;
            end
            sprq_pkg::ST_FINISH: begin
                cmd.finish = 1'b1;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // Result valid: set on finish, drop once the transfer completes
    always_comb begin
        mv_next = mv_reg;
        if (m_tready) mv_next = 1'b0;
        if (state_reg == sprq_pkg::ST_FINISH) mv_next = 1'b1;
    end

    assign m_tvalid = mv_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= sprq_pkg::ST_IDLE;
            mv_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            mv_reg    <= mv_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/sleep_and_priority_ready_queue.sv */
// Top level of the task scheduler with priority ready queue and sleep queue.
//
//  channel  | direction | tdata fields (low bit first)
//  s_axis   | in        | op, task_id, task_priority, tick_value, running_priority
//  m_axis   | out       | next_task, next_valid, preempt, woken_count, status
//
// Make ready, sleep and pick go from the input transfer through the execute and finish states to result valid.
// A timer tick also passes through the wake state, with one wake step for each sleeper due.
// One operation at a time; the next input waits until the result is taken.
// Reset clears both queue counts; the cell rows need no clearing.
`default_nettype none
module sleep_and_priority_ready_queue #(
    parameter int MAX_TASKS       = 64,
    parameter int PRIORITY_LEVELS = 64
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // op[1:0], task_id[9:2], task_priority[15:10], tick_value[47:16],
    // running_priority[53:48]
    input  wire logic [sprq_pkg::S_DATA_W-1:0] s_tdata,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // next_task[7:0], next_valid[8], preempt[9], woken_count[16:10], status[17]
    output logic [sprq_pkg::M_DATA_W-1:0]      m_tdata
);
    sprq_pkg::cmd_t cmd;
    sprq_pkg::sts_t sts;

    sprq_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sprq_datapath #(
        .MAX_TASKS       (MAX_TASKS),
        .PRIORITY_LEVELS (PRIORITY_LEVELS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_data  (s_tdata),
        .cmd      (cmd),
        .sts      (sts),
        .out_data (m_tdata)
    );

    // Never take input while a result is pending
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while result pending");

    // An accepted transfer blocks input on the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input ready right after a transfer");

    // A popped task never comes with woken sleepers
    a_pick_alone: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[8]) |-> (m_tdata[16:10] == 7'd0 && !m_tdata[9]))
        else $error("pick result mixed with tick result");

endmodule
`default_nettype wire

/* tb/sprq_checker.sv */
// Checker for the scheduler: predicts each result from the input transfers and compares.
`timescale 1ns / 100ps
`default_nettype none
module sprq_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [sprq_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [sprq_pkg::M_DATA_W-1:0] m_tdata,
    output int                                 fail_count,
    output int                                 pending
);
    localparam int DEPTH = 64;

    typedef struct packed {
        logic [7:0] id;
        logic [5:0] prio;
    } rdy_t;

    typedef struct packed {
        logic [7:0]  id;
        logic [5:0]  prio;
        logic [31:0] wake;
    } slp_t;

    typedef struct packed {
        logic       status;
        logic [6:0] woken;
        logic       preempt;
        logic       nvalid;
        logic [7:0] ntask;
    } res_t;

    rdy_t ready_q[$];
    slp_t sleep_q[$];
    res_t sched_results[$];

    assign pending = sched_results.size();

    // Insert behind every task of equal or higher priority
    function automatic bit ready_push(rdy_t r);
        int pos;
        pos = 0;
        if (ready_q.size() >= DEPTH) return 0;
        while (pos < ready_q.size() && ready_q[pos].prio >= r.prio) pos++;
        ready_q.insert(pos, r);
        return 1;
    endfunction

    function automatic logic front_preempts(logic [5:0] run);
        if (ready_q.size() == 0) return 0;
        return ready_q[0].prio >= run;
    endfunction

    // Apply one operation to the queue copies and return its result
    function automatic res_t schedule_step(logic [sprq_pkg::S_DATA_W-1:0] d);
        res_t r;
        slp_t s;
        rdy_t t;
        int pos;
        logic [1:0]  op;
        logic [31:0] tick;
        logic [5:0]  run;
        r = '0;
        op = d[1:0];
        tick = d[47:16];
        run = d[53:48];
        case (op)
            sprq_pkg::OP_READY: begin
                t.id = d[9:2];
                t.prio = d[15:10];
                if (!ready_push(t)) r.status = 1;
                r.preempt = front_preempts(run);
            end
            sprq_pkg::OP_SLEEP: begin
                s.id = d[9:2];
                s.prio = d[15:10];
                s.wake = tick;
                if (sleep_q.size() >= DEPTH) begin
                    r.status = 1;
                end else begin
                    pos = 0;
                    while (pos < sleep_q.size() && sleep_q[pos].wake <= tick) pos++;
                    sleep_q.insert(pos, s);
                end
            end
            sprq_pkg::OP_TICK: begin
                while (sleep_q.size() > 0 && sleep_q[0].wake <= tick) begin
                    s = sleep_q.pop_front();
                    t.id = s.id;
                    t.prio = s.prio;
                    if (ready_push(t)) begin
                        if (r.woken != 7'd127) r.woken++;
                    end else begin
                        r.status = 1;
                    end
                end
                r.preempt = front_preempts(run);
            end
            default: begin
                if (ready_q.size() > 0) begin
                    t = ready_q.pop_front();
                    r.ntask = t.id;
                    r.nvalid = 1;
                end
            end
        endcase
        return r;
    endfunction

    // Predict on input transfers, compare on result transfers
    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (!aresetn) begin
            ready_q.delete();
            sleep_q.delete();
            sched_results.delete();
            fail_count <= 0;
        end else begin
            if (s_tvalid && s_tready) sched_results.push_back(schedule_step(s_tdata));
            if (m_tvalid && m_tready) begin
                got = m_tdata[17:0];
                if (sched_results.size() == 0) begin
                    if (fail_count < 10)
                        $display("unexpected result transfer %h", got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = sched_results.pop_front();
                    if (got !== want) begin
                        if (fail_count < 10)
                            $display({"mismatch: task %h/%h valid %b/%b preempt %b/%b",
                                      " woken %0d/%0d status %b/%b (exp/act)"},
                                want.ntask, got.ntask, want.nvalid, got.nvalid,
                                want.preempt, got.preempt, want.woken, got.woken,
                                want.status, got.status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

/* tb/tb_sleep_and_priority_ready_queue.sv */
// Testbench top: drives scheduler operations and gives the verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb_sleep_and_priority_ready_queue;
    logic                          aclk;
    logic                          aresetn;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [sprq_pkg::S_DATA_W-1:0] s_tdata;
    logic                          m_tvalid;
    logic                          m_tready;
    logic [sprq_pkg::M_DATA_W-1:0] m_tdata;
    int                            fail_count;
    int                            pending;
    int                            cycles;
    int                            send_idle;
    int                            recv_idle;
    logic [31:0]                   now_tick;

    sleep_and_priority_ready_queue u_top (.*);

    sprq_checker u_chk (.*);

    initial begin
        aclk = 0;
        forever #10 aclk = ~aclk;
    end

    // Bound the run
    initial begin
        cycles = 0;
        forever begin
            @(posedge aclk);
            cycles++;
            if (cycles > 2000000) begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    // Receiver stalls
    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle);
    end

    // Offer one operation and hold it until taken; returns at the next falling edge
    task automatic issue(logic [1:0] op, logic [7:0] id, logic [5:0] prio,
                         logic [31:0] tick, logic [5:0] run);
        while ($urandom_range(99) < send_idle) begin
            s_tvalid <= 0;
            @(negedge aclk);
        end
        s_tvalid <= 1;
        s_tdata <= {2'b00, run, tick, prio, id, op};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    // Mostly well-formed traffic around a moving time base
    task automatic random_op();
        int k;
        logic [31:0] t;
        k = $urandom_range(99);
        if ($urandom_range(49) == 0) t = $urandom;
        else t = now_tick + $urandom_range(40);
        if (k < 30) begin
            issue(sprq_pkg::OP_READY, 8'($urandom), 6'($urandom), $urandom, 6'($urandom));
        end else if (k < 58) begin
            issue(sprq_pkg::OP_SLEEP, 8'($urandom), 6'($urandom), t, 6'($urandom));
        end else if (k < 75) begin
            now_tick = now_tick + $urandom_range(20);
            issue(sprq_pkg::OP_TICK, 8'($urandom), 6'($urandom), now_tick, 6'($urandom));
        end else begin
            issue(sprq_pkg::OP_PICK, 8'($urandom), 6'($urandom), $urandom, 6'($urandom));
        end
    endtask

    initial begin
        int i;
        aresetn = 0;
        s_tvalid = 0;
        s_tdata = '0;
        m_tready = 0;
        send_idle = 0;
        recv_idle = 0;
        now_tick = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Directed: empty pop, extremes, equal priorities, equal ticks
        issue(sprq_pkg::OP_PICK, 8'hFF, 6'h3F, 32'hFFFFFFFF, 6'h3F);
        issue(sprq_pkg::OP_TICK, 8'h00, 6'h00, 32'hFFFFFFFF, 6'h00);
        issue(sprq_pkg::OP_READY, 8'h00, 6'h00, 32'h0, 6'h00);
        issue(sprq_pkg::OP_READY, 8'hFF, 6'h3F, 32'hFFFFFFFF, 6'h3F);
        issue(sprq_pkg::OP_READY, 8'h5A, 6'h3F, 32'h0, 6'h00);
        issue(sprq_pkg::OP_READY, 8'hA5, 6'h10, 32'h0, 6'h3F);
        issue(sprq_pkg::OP_SLEEP, 8'h11, 6'h20, 32'd5, 6'h0);
        issue(sprq_pkg::OP_SLEEP, 8'h22, 6'h20, 32'd5, 6'h0);
        issue(sprq_pkg::OP_SLEEP, 8'h33, 6'h3F, 32'hFFFFFFFF, 6'h0);
        issue(sprq_pkg::OP_SLEEP, 8'h44, 6'h00, 32'd0, 6'h0);
        issue(sprq_pkg::OP_TICK, 8'h0, 6'h0, 32'd5, 6'h21);
        issue(sprq_pkg::OP_TICK, 8'h0, 6'h0, 32'hFFFFFFFF, 6'h3F);
        for (i = 0; i < 9; i++) issue(sprq_pkg::OP_PICK, 8'h0, 6'h0, 32'h0, 6'h0);
        // Fill the sleep queue past full, wake all into a ready queue past full
        for (i = 0; i < 66; i++)
            issue(sprq_pkg::OP_SLEEP, 8'(i), 6'(i), 32'(i % 7), 6'h0);
        for (i = 0; i < 10; i++) issue(sprq_pkg::OP_READY, 8'(i), 6'h3F, 32'h0, 6'h0);
        issue(sprq_pkg::OP_TICK, 8'h0, 6'h0, 32'd10, 6'h0);
        issue(sprq_pkg::OP_READY, 8'h77, 6'h01, 32'h0, 6'h01);
        for (i = 0; i < 66; i++) issue(sprq_pkg::OP_PICK, 8'h0, 6'h0, 32'h0, 6'h0);

        // Random phases with different idling
        for (i = 0; i < 1650; i++) begin
            if (i == 0) begin
                send_idle = 29; recv_idle = 86;
            end else if (i == 550) begin
                send_idle = 86; recv_idle = 29;
            end else if (i == 1100) begin
                send_idle = 0; recv_idle = 0;
            end
            random_op();
        end
        s_tvalid <= 0;

        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
`default_nettype wire
